/* sv/fpaxpy_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fpaxpy_pkg
// Shared types, constants and helpers of the single-precision fused AXPY unit.
// ----------------------------------------------------------------------------
package fpaxpy_pkg;

	localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
	localparam logic [30:0] INF_MAG   = 31'h7F80_0000;
	localparam logic        REG_ALPHA = 1'b0;

	typedef logic signed [11:0] exp_t;

	typedef struct packed {
		logic        valid;
		logic        last;
		logic        spec;
		logic [31:0] spec_bits;
		logic        sign;
		logic [61:0] mag;
		exp_t        exp;
	} rnd_in_t;

	function automatic logic [6:0] msb_idx(input logic [63:0] v);
		logic [6:0] p;
		p = '0;
		for (int i = 0; i < 64; i++) begin
			if (v[i]) p = 7'(i);
		end
		return p;
	endfunction

endpackage
`default_nettype wire

/* sv/fp32_axpy_fma_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fp32_axpy_fma_unit
// Streaming y + alpha*x in binary32 with a single rounding to nearest even.
// ----------------------------------------------------------------------------
// Usage:
//   Program alpha through the APB port (register 0, byte address 0) while
//   no element is in flight. Pulse start with x_bits, y_bits and is_last;
//   busy is always low, so a new element is taken on every cycle.
//   Each element comes out at the end of the pipeline, with done
//   high for one cycle alongside y_result_bits and last_out.
//   Throughput is one element per cycle; the six register stages are:
//   multiply, normalise, align and add, leading-one search, rounding
//   shift, round and pack.
//   The receiver cannot stall; results must be taken as they appear.
//   Reset clears the pipeline valid bits and sets alpha to +0.0.
// ----------------------------------------------------------------------------
module fp32_axpy_fma_unit import fpaxpy_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [31:0] x_bits,
	input  wire logic [31:0] y_bits,
	input  wire logic        is_last,
	output logic             done,
	output logic [31:0]      y_result_bits,
	output logic             last_out,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic [31:0] alpha_q;

	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign prdata = (paddr[2] == REG_ALPHA) ? alpha_q : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= '0;
		end else if (psel && penable && pwrite && paddr[2] == REG_ALPHA) begin
			alpha_q <= pwdata;
		end
	end

	// stage 1: unpack, special cases, significand product
	logic        sp, sy;
	logic        a_nan, x_nan, y_nan, a_inf, x_inf, y_inf, a_zero, x_zero, y_zero;
	logic        nan, spec;
	logic [31:0] spec_bits;
	logic [23:0] ma, mx, my;
	exp_t        ea, ex, ey;

	always_comb begin
		sp     = alpha_q[31] ^ x_bits[31];
		sy     = y_bits[31];
		a_nan  = alpha_q[30:0] > INF_MAG;
		x_nan  = x_bits[30:0] > INF_MAG;
		y_nan  = y_bits[30:0] > INF_MAG;
		a_inf  = alpha_q[30:0] == INF_MAG;
		x_inf  = x_bits[30:0] == INF_MAG;
		y_inf  = y_bits[30:0] == INF_MAG;
		a_zero = alpha_q[30:0] == '0;
		x_zero = x_bits[30:0] == '0;
		y_zero = y_bits[30:0] == '0;
		nan = a_nan | x_nan | y_nan | (a_inf & x_zero) | (x_inf & a_zero)
			| ((a_inf | x_inf) & y_inf & (sy != sp));
		spec = nan | a_inf | x_inf | y_inf | a_zero | x_zero;
		priority if (nan) begin
			spec_bits = QNAN_BITS;
		end else if (a_inf || x_inf) begin
			spec_bits = {sp, INF_MAG};
		end else if (y_inf) begin
			spec_bits = y_bits;
		end else if (y_zero) begin
			spec_bits = {sp & sy, 31'b0};
		end else begin
			spec_bits = y_bits;
		end
		ma = {alpha_q[30:23] != '0, alpha_q[22:0]};
		mx = {x_bits[30:23] != '0, x_bits[22:0]};
		my = {y_bits[30:23] != '0, y_bits[22:0]};
		ea = (alpha_q[30:23] == '0) ? exp_t'(-149)
			: exp_t'($signed({4'b0, alpha_q[30:23]})) - exp_t'(150);
		ex = (x_bits[30:23] == '0) ? exp_t'(-149)
			: exp_t'($signed({4'b0, x_bits[30:23]})) - exp_t'(150);
		ey = (y_bits[30:23] == '0) ? exp_t'(-149)
			: exp_t'($signed({4'b0, y_bits[30:23]})) - exp_t'(150);
	end

	logic        valid_s1, valid_s2, valid_s3;
	logic        last_s1, last_s2, last_s3;
	logic        spec_s1, spec_s2, spec_s3;
	logic [31:0] spec_bits_s1, spec_bits_s2, spec_bits_s3;
	logic        sp_s1, sy_s1, yz_s1;
	logic [47:0] mp_s1;
	logic [23:0] my_s1;
	exp_t        ep_s1, ey_s1;

	always_ff @(posedge clk) begin
		last_s1      <= is_last;
		spec_s1      <= spec;
		spec_bits_s1 <= spec_bits;
		sp_s1        <= sp;
		sy_s1        <= sy;
		yz_s1        <= y_zero;
		mp_s1        <= ma * mx;
		my_s1        <= my;
		ep_s1        <= ea + ex;
		ey_s1        <= ey;
	end

	// stage 2: normalise both addends to bit 60, order by magnitude
	logic [6:0]  pm, py, smp, smy;
	logic [60:0] mpn, myn;
	exp_t        epn, eyn;
	logic        p_big;

	always_comb begin
		pm  = msb_idx({16'b0, mp_s1});
		py  = msb_idx({40'b0, my_s1});
		smp = 7'd60 - pm;
		smy = 7'd60 - py;
		mpn = 61'(mp_s1) << smp[5:0];
		myn = 61'(my_s1) << smy[5:0];
		epn = ep_s1 - exp_t'($signed({5'b0, smp}));
		eyn = ey_s1 - exp_t'($signed({5'b0, smy}));
		p_big = yz_s1 || (epn > eyn) || (epn == eyn && mpn >= myn);
	end

	logic [60:0] lm_s2, sm_s2;
	exp_t        le_s2, d_s2;
	logic        ls_s2, eff_sub_s2;

	always_ff @(posedge clk) begin
		last_s2      <= last_s1;
		spec_s2      <= spec_s1;
		spec_bits_s2 <= spec_bits_s1;
		lm_s2        <= p_big ? mpn : myn;
		sm_s2        <= yz_s1 ? '0 : (p_big ? myn : mpn);
		le_s2        <= p_big ? epn : eyn;
		d_s2         <= p_big ? (epn - eyn) : (eyn - epn);
		ls_s2        <= p_big ? sp_s1 : sy_s1;
		eff_sub_s2   <= sp_s1 ^ sy_s1;
	end

	// stage 3: align the smaller addend with sticky, add or subtract
	logic [5:0]   dd;
	logic [123:0] al;
	logic [60:0]  sma;
	logic [61:0]  r;

	always_comb begin
		dd  = (d_s2 >= exp_t'(63)) ? 6'd63 : d_s2[5:0];
		al  = {sm_s2, 63'b0} >> dd;
		sma = al[123:63] | 61'(|al[62:0]);
		r   = eff_sub_s2 ? ({1'b0, lm_s2} - {1'b0, sma}) : ({1'b0, lm_s2} + {1'b0, sma});
	end

	logic [61:0] r_s3;
	exp_t        le_s3;
	logic        ls_s3;

	always_ff @(posedge clk) begin
		last_s3      <= last_s2;
		spec_s3      <= spec_s2;
		spec_bits_s3 <= spec_bits_s2;
		r_s3         <= r;
		le_s3        <= le_s2;
		ls_s3        <= (r == '0) ? 1'b0 : ls_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= start & ~busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	rnd_in_t rin;

	always_comb begin
		rin.valid     = valid_s3;
		rin.last      = last_s3;
		rin.spec      = spec_s3;
		rin.spec_bits = spec_bits_s3;
		rin.sign      = ls_s3;
		rin.mag       = r_s3;
		rin.exp       = le_s3;
	end

	fpaxpy_round u_round (
		.clk           (clk),
		.arst_n        (arst_n),
		.rin           (rin),
		.done          (done),
		.y_result_bits (y_result_bits),
		.last_out      (last_out)
	);

	a_busy_low: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##6 done)
		else $error("transfer lost in pipeline");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##6 (last_out == $past(is_last, 6)))
		else $error("last mark corrupted");

	a_nan_x: assert property (@(posedge clk) disable iff (!arst_n)
		(start && x_bits[30:23] == 8'hFF && x_bits[22:0] != 23'b0)
		|-> ##6 (y_result_bits == QNAN_BITS))
		else $error("NaN not propagated");

endmodule
`default_nettype wire

/* sv/fpaxpy_round.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fpaxpy_round
// Normalise, round to nearest even and pack the exact sum into binary32, or pass a special-case result through.
// ----------------------------------------------------------------------------
module fpaxpy_round import fpaxpy_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire rnd_in_t     rin,
	output logic             done,
	output logic [31:0]      y_result_bits,
	output logic             last_out
);

	logic        valid_s4, valid_s5, valid_s6;
	logic        last_s4, last_s5, last_s6;
	logic        spec_s4, spec_s5;
	logic [31:0] spec_bits_s4, spec_bits_s5;
	logic        sign_s4, sign_s5;
	logic [61:0] mag_s4;
	exp_t        sh_s4, k_s4, k_s5;
	logic [24:0] q_s5;
	logic        rb_s5, st_s5;
	logic [31:0] res_s6;

	logic [6:0]   p;
	exp_t         sh_a, sh_b, sh;
	logic [125:0] ext;
	logic [24:0]  q_n;
	logic         rb_n, st_n;
	logic         inc;
	logic [24:0]  q2, q3;
	exp_t         k3, be;
	logic [31:0]  res_n;

	always_comb begin
		p    = msb_idx({2'b0, rin.mag});
		sh_a = exp_t'($signed({5'b0, p})) - exp_t'(23);
		sh_b = exp_t'(-149) - rin.exp;
		sh   = (sh_b > sh_a) ? sh_b : sh_a;
	end

	always_comb begin
		ext  = {mag_s4, 64'b0} >> sh_s4[5:0];
		q_n  = '0;
		rb_n = 1'b0;
		st_n = 1'b0;
		if (sh_s4 < 0) begin
			q_n = 25'(mag_s4 << (6'(-sh_s4)));
		end else if (sh_s4 < exp_t'(64)) begin
			q_n  = ext[88:64];
			rb_n = ext[63];
			st_n = |ext[62:0];
		end
	end

	always_comb begin
		inc = rb_s5 & (st_s5 | q_s5[0]);
		q2  = q_s5 + 25'(inc);
		q3  = q2;
		k3  = k_s5;
		if (q2[24]) begin
			q3 = q2 >> 1;
			k3 = k_s5 + exp_t'(1);
		end
		be = k3 + exp_t'(150);
		if (spec_s5) begin
			res_n = spec_bits_s5;
		end else if (q3 == '0) begin
			res_n = {sign_s5, 31'b0};
		end else if (!q3[23]) begin
			res_n = {sign_s5, 8'b0, q3[22:0]};
		end else if (be >= exp_t'(255)) begin
			res_n = {sign_s5, INF_MAG};
		end else begin
			res_n = {sign_s5, be[7:0], q3[22:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			valid_s4 <= rin.valid;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		last_s4      <= rin.last;
		spec_s4      <= rin.spec;
		spec_bits_s4 <= rin.spec_bits;
		sign_s4      <= rin.sign;
		mag_s4       <= rin.mag;
		sh_s4        <= sh;
		k_s4         <= rin.exp + sh;
		last_s5      <= last_s4;
		spec_s5      <= spec_s4;
		spec_bits_s5 <= spec_bits_s4;
		sign_s5      <= sign_s4;
		k_s5         <= k_s4;
		q_s5         <= q_n;
		rb_s5        <= rb_n;
		st_s5        <= st_n;
		last_s6      <= last_s5;
		res_s6       <= res_n;
	end

	assign done          = valid_s6;
	assign y_result_bits = res_s6;
	assign last_out      = last_s6;

endmodule
`default_nettype wire
